/* rtl/ofdm_bi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OFDM bit interleaver package
// Shared types, register indexes and modulation lookup functions.
// ----------------------------------------------------------------------------
package ofdm_bi_pkg;

    localparam int MAX_BLOCK_BITS_DEF = 288;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION  = 2'd1;

    localparam logic [1:0] MOD_BPSK  = 2'd0;
    localparam logic [1:0] MOD_QPSK  = 2'd1;
    localparam logic [1:0] MOD_QAM16 = 2'd2;
    localparam logic [1:0] MOD_QAM64 = 2'd3;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_READ,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic wr;
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic bit_last;
        logic byte_last;
        logic out_free;
    } t_status;

    function automatic logic [5:0] block_bytes(input logic [1:0] modulation);
        logic [5:0] n;
        case (modulation)
            MOD_BPSK:  n = 6'd6;
            MOD_QPSK:  n = 6'd12;
            MOD_QAM16: n = 6'd24;
            MOD_QAM64: n = 6'd36;
            default:   n = 6'd6;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] column_depth(input logic [1:0] modulation);
        logic [4:0] d;
        case (modulation)
            MOD_BPSK:  d = 5'd3;
            MOD_QPSK:  d = 5'd6;
            MOD_QAM16: d = 5'd12;
            MOD_QAM64: d = 5'd18;
            default:   d = 5'd3;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] group_size(input logic [1:0] modulation);
        logic [1:0] s;
        case (modulation)
            MOD_BPSK:  s = 2'd1;
            MOD_QPSK:  s = 2'd1;
            MOD_QAM16: s = 2'd2;
            MOD_QAM64: s = 2'd3;
            default:   s = 2'd1;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/ofdm_bi_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OFDM bit interleaver controller
// Sequences block fill, per-bit buffer reads and output byte loads.
// ----------------------------------------------------------------------------
module ofdm_bi_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire ofdm_bi_pkg::t_status i_status,
    output ofdm_bi_pkg::t_cmd         o_cmd
);

    ofdm_bi_pkg::t_state r_state;
    ofdm_bi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ofdm_bi_pkg::ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ofdm_bi_pkg::ST_FILL: begin
                o_in_ready = 1'b1;
                o_cmd.wr   = i_in_valid;
                if (i_in_valid && i_status.fill_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = ofdm_bi_pkg::ST_READ;
                end
            end
            ofdm_bi_pkg::ST_READ: begin
                o_cmd.step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = ofdm_bi_pkg::ST_DRAIN;
                end
            end
            ofdm_bi_pkg::ST_DRAIN: begin
                n_state = ofdm_bi_pkg::ST_HOLD;
            end
            ofdm_bi_pkg::ST_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.byte_last) begin
                        n_state = ofdm_bi_pkg::ST_FILL;
                    end else begin
                        n_state = ofdm_bi_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = ofdm_bi_pkg::ST_FILL;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ofdm_bi_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OFDM bit interleaver datapath
// Block buffer, permutation address counters, bit gather and output register.
// ----------------------------------------------------------------------------
module ofdm_bi_datapath #(
    parameter int MAX_BLOCK_BITS = ofdm_bi_pkg::MAX_BLOCK_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire ofdm_bi_pkg::t_cmd               i_cmd,
    output ofdm_bi_pkg::t_status                 o_status,
    input  wire                                  i_cfg_we,
    input  wire [ofdm_bi_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [ofdm_bi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire [7:0]                            i_data_byte,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_last_of_block
);

    localparam int MEM_DEPTH = (MAX_BLOCK_BITS + 7) / 8;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [7:0] r_mem [MEM_DEPTH];

    logic [1:0] r_modulation;
    logic       r_direction;
    logic [5:0] r_byte_cnt;
    logic [5:0] n_byte_cnt;

    logic [2:0] r_bit_cnt;
    logic [5:0] r_byte_out;
    logic [3:0] r_t;
    logic [1:0] r_tm;
    logic [4:0] r_gb;
    logic [1:0] r_qr;
    logic [3:0] r_c;
    logic [1:0] r_cm;
    logic [4:0] r_rb;
    logic [1:0] r_rr;
    logic [3:0] n_t;
    logic [1:0] n_tm;
    logic [4:0] n_gb;
    logic [1:0] n_qr;
    logic [3:0] n_c;
    logic [1:0] n_cm;
    logic [4:0] n_rb;
    logic [1:0] n_rr;

    logic [7:0] r_rd_data;
    logic [2:0] r_rd_sel;
    logic       r_rd_zero;
    logic       r_rd_vld;
    logic [7:0] r_gather;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [5:0] nbytes;
    logic [4:0] dd;
    logic [1:0] ss;
    logic [5:0] wr_idx;
    logic       wr_in_range;
    logic [2:0] sum0;
    logic [2:0] rot0;
    logic [4:0] m_in;
    logic [8:0] p0;
    logic [1:0] rot1;
    logic [8:0] prod1;
    logic [8:0] p1;
    logic [8:0] p;
    logic [5:0] rd_byte;
    logic [AW-1:0] rd_addr;
    logic       rd_bit;

    assign nbytes      = ofdm_bi_pkg::block_bytes(r_modulation);
    assign dd          = ofdm_bi_pkg::column_depth(r_modulation);
    assign ss          = ofdm_bi_pkg::group_size(r_modulation);
    assign wr_idx      = (r_byte_cnt >= nbytes) ? 6'd0 : r_byte_cnt;
    assign wr_in_range = wr_idx < 6'(MEM_DEPTH);

    // Source bit for the output bit under the inverse of the transmit mapping.
    assign sum0 = {1'b0, r_qr} + {1'b0, r_tm};
    assign rot0 = (sum0 >= {1'b0, ss}) ? (sum0 - {1'b0, ss}) : sum0;
    assign m_in = r_gb + 5'(rot0);
    assign p0   = {m_in, r_t};

    // Source bit for the output bit under the transmit mapping.
    assign rot1  = (r_rr >= r_cm) ? (r_rr - r_cm) : (r_rr + ss - r_cm);
    assign prod1 = 9'(dd) * 9'(r_c);
    assign p1    = prod1 + 9'(r_rb) + 9'(rot1);

    assign p       = r_direction ? p1 : p0;
    assign rd_byte = p[8:3];
    assign rd_addr = (rd_byte < 6'(MEM_DEPTH)) ? rd_byte[AW-1:0] : '0;
    assign rd_bit  = r_rd_zero ? 1'b0 : r_rd_data[3'd7 - r_rd_sel];

    assign o_status.fill_last = (wr_idx + 6'd1) == nbytes;
    assign o_status.bit_last  = r_bit_cnt == 3'd7;
    assign o_status.byte_last = r_byte_out == (nbytes - 6'd1);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_block = r_out_last;

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        if (i_cfg_we && (i_cfg_index == ofdm_bi_pkg::CFG_MODULATION)) begin
            n_byte_cnt = 6'd0;
        end else if (i_cmd.wr) begin
            n_byte_cnt = o_status.fill_last ? 6'd0 : (wr_idx + 6'd1);
        end
    end

    always_comb begin
        n_t  = r_t;
        n_tm = r_tm;
        n_gb = r_gb;
        n_qr = r_qr;
        n_c  = r_c;
        n_cm = r_cm;
        n_rb = r_rb;
        n_rr = r_rr;
        if (i_cmd.start) begin
            n_t  = '0;
            n_tm = '0;
            n_gb = '0;
            n_qr = '0;
            n_c  = '0;
            n_cm = '0;
            n_rb = '0;
            n_rr = '0;
        end else if (i_cmd.step) begin
            if ((r_qr + 2'd1) == ss) begin
                n_qr = 2'd0;
                if ((r_gb + 5'(ss)) == dd) begin
                    n_gb = 5'd0;
                    n_t  = r_t + 4'd1;
                    n_tm = ((r_tm + 2'd1) == ss) ? 2'd0 : (r_tm + 2'd1);
                end else begin
                    n_gb = r_gb + 5'(ss);
                end
            end else begin
                n_qr = r_qr + 2'd1;
            end
            n_c = r_c + 4'd1;
            if (r_c == 4'd15) begin
                n_cm = 2'd0;
                if ((r_rr + 2'd1) == ss) begin
                    n_rr = 2'd0;
                    n_rb = r_rb + 5'(ss);
                end else begin
                    n_rr = r_rr + 2'd1;
                end
            end else begin
                n_cm = ((r_cm + 2'd1) == ss) ? 2'd0 : (r_cm + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_in_range) begin
            r_mem[wr_idx[AW-1:0]] <= i_data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulation <= 2'd0;
            r_direction  <= 1'b0;
            r_byte_cnt   <= 6'd0;
            r_bit_cnt    <= 3'd0;
            r_byte_out   <= 6'd0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_t          <= '0;
            r_tm         <= '0;
            r_gb         <= '0;
            r_qr         <= '0;
            r_c          <= '0;
            r_cm         <= '0;
            r_rb         <= '0;
            r_rr         <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == ofdm_bi_pkg::CFG_MODULATION)) begin
                r_modulation <= i_cfg_data[1:0];
            end
            if (i_cfg_we && (i_cfg_index == ofdm_bi_pkg::CFG_DIRECTION)) begin
                r_direction <= i_cfg_data[0];
            end
            r_byte_cnt <= n_byte_cnt;
            r_t        <= n_t;
            r_tm       <= n_tm;
            r_gb       <= n_gb;
            r_qr       <= n_qr;
            r_c        <= n_c;
            r_cm       <= n_cm;
            r_rb       <= n_rb;
            r_rr       <= n_rr;
            if (i_cmd.start) begin
                r_bit_cnt <= 3'd0;
            end else if (i_cmd.step) begin
                r_bit_cnt <= r_bit_cnt + 3'd1;
            end
            if (i_cmd.start) begin
                r_byte_out <= 6'd0;
            end else if (i_cmd.load) begin
                r_byte_out <= r_byte_out + 6'd1;
            end
            r_rd_vld <= i_cmd.step;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sel  <= p[2:0];
        r_rd_zero <= p >= 9'(MAX_BLOCK_BITS);
        if (r_rd_vld) begin
            r_gather <= {r_gather[6:0], rd_bit};
        end
        if (i_cmd.load) begin
            r_out_byte <= r_gather;
            r_out_last <= o_status.byte_last;
        end
    end

endmodule
`default_nettype wire

/* rtl/ofdm_block_bit_interleaver.sv */
`timescale 1ns / 1ps
`default_nettype none
// Input bytes are taken one per cycle until the block (6, 12, 24 or 36 bytes) is full.
// Each output byte then takes 8 single-bit reads of the one-port byte buffer, a drain state
// for the last read to land and a hold state that loads the output register once it is free.
// Reset clears control state and both registers to 0; the buffer contents are not cleared,
// every bit is written before it is read.
// ----------------------------------------------------------------------------
// OFDM block bit interleaver
// Buffers one OFDM symbol of coded bits and emits it interleaved or deinterleaved.
// ----------------------------------------------------------------------------
module ofdm_block_bit_interleaver #(
    parameter int MAX_BLOCK_BITS = ofdm_bi_pkg::MAX_BLOCK_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [ofdm_bi_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [ofdm_bi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [7:0]                          i_data_byte,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last_of_block
);

    ofdm_bi_pkg::t_cmd    cmd;
    ofdm_bi_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    ofdm_bi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ofdm_bi_datapath #(
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_last_of_block (o_last_of_block)
    );

    a_start_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !o_in_ready)
        else $error("input still ready after the final byte of a block");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_out_valid)
        else $error("output byte not presented after load");

    a_no_fill_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.step && cmd.wr))
        else $error("buffer read and write transfer in the same cycle");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && status.byte_last) |=> o_last_of_block)
        else $error("final byte of the block not flagged");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OFDM block bit interleaver testbench
// Drives coded bytes and register writes through valid/ready channels and
// compares every emitted byte against a bit-level model of the interleaver.
// Runs directed blocks, a long receiver stall and randomized phases.
// ----------------------------------------------------------------------------
module testbench;
    import ofdm_bi_pkg::*;

    localparam int          ITEMS_TARGET  = 410;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam logic        DIR_TX        = 1'b0;
    localparam logic        DIR_RX        = 1'b1;
    localparam logic [1:0]  CFG_SPARE_A   = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B   = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [1:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_last_of_block;

    out_byte_t  permuted_q[$];
    logic [0:287] symbol_bits;
    logic [5:0] fill_count;
    logic [1:0] cur_mod;
    logic       cur_dir;
    int         error_count;
    int         bytes_accepted;
    bit         no_gaps;
    int         hold_req;

    ofdm_block_bit_interleaver uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_block (o_last_of_block)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int unsigned interleave_pos(input int unsigned p, input int unsigned nbits,
                                                   input int unsigned span);
        int unsigned m;
        m = (nbits / 16) * (p % 16) + p / 16;
        return span * (m / span) + (m + nbits - (16 * m) / nbits) % span;
    endfunction

    function automatic int unsigned deinterleave_pos(input int unsigned p,
                                                     input int unsigned nbits,
                                                     input int unsigned span);
        int unsigned m;
        m = span * (p / span) + (p + (16 * p) / nbits) % span;
        return 16 * m - (nbits - 1) * ((16 * m) / nbits);
    endfunction

    function automatic void permute_byte(input logic [7:0] b);
        int unsigned bpc;
        int unsigned nbits;
        int unsigned nbytes;
        int unsigned span;
        int unsigned pos;
        int unsigned q;
        logic [7:0]  shuffled [36];
        out_byte_t   e;
        case (cur_mod)
            MOD_BPSK:  bpc = 1;
            MOD_QPSK:  bpc = 2;
            MOD_QAM16: bpc = 4;
            default:   bpc = 6;
        endcase
        nbits  = 48 * bpc;
        nbytes = nbits / 8;
        span   = (bpc / 2 >= 1) ? bpc / 2 : 1;
        if (fill_count >= nbytes) fill_count = '0;
        for (int i = 0; i < 8; i++) begin
            pos = fill_count * 8 + i;
            if (pos < 288) symbol_bits[pos] = b[7 - i];
        end
        fill_count = fill_count + 6'd1;
        if (fill_count < nbytes) return;
        for (int i = 0; i < 36; i++) shuffled[i] = 8'h00;
        for (int unsigned p = 0; p < nbits; p++) begin
            q = (cur_dir == DIR_RX) ? deinterleave_pos(p, nbits, span)
                                    : interleave_pos(p, nbits, span);
            if (q < nbits) shuffled[q / 8][7 - q % 8] = symbol_bits[p];
        end
        for (int unsigned i = 0; i < nbytes; i++) begin
            e.data = shuffled[i];
            e.last = (i + 1 == nbytes);
            permuted_q.push_back(e);
        end
        fill_count = '0;
    endfunction

    // Output checker: one expected byte per output transfer.
    initial begin
        out_byte_t e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (permuted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", o_out_byte));
                end else begin
                    e = permuted_q.pop_front();
                    if (o_out_byte !== e.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h", o_out_byte, e.data));
                    if (o_last_of_block !== e.last)
                        report_mismatch($sformatf("last_of_block %b, want %b",
                                                  o_last_of_block, e.last));
                end
            end
        end
    end

    // Receiver: random stalls, steady stretches and a long hold-off on request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (no_gaps) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= 32);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 32) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        do @(posedge i_clk); while (!o_in_ready);
        permute_byte(b);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_block(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic wait_idle;
        i_in_valid = 1'b0;
        while (permuted_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODULATION: begin
                cur_mod    = val;
                fill_count = '0;
            end
            CFG_DIRECTION: begin
                cur_dir = val[0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic int block_len(input logic [1:0] m);
        case (m)
            MOD_BPSK:  return 6;
            MOD_QPSK:  return 12;
            MOD_QAM16: return 24;
            default:   return 36;
        endcase
    endfunction

    task automatic test_bpsk_both_directions;
        wait_idle();
        cfg_write(CFG_MODULATION, MOD_BPSK);
        cfg_write(CFG_DIRECTION, {1'b0, DIR_TX});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(8'hAA);
        wait_idle();
        cfg_write(CFG_DIRECTION, 2'b11);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'hAA);
        send_byte(8'h55);
    endtask

    task automatic test_rewrites_mid_block;
        wait_idle();
        send_byte(8'hC3);
        send_byte(8'h3C);
        send_byte(8'h81);
        wait_idle();
        cfg_write(CFG_MODULATION, MOD_BPSK);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        wait_idle();
        cfg_write(CFG_DIRECTION, 2'b10);
        cfg_write(CFG_SPARE_A, 2'b11);
        cfg_write(CFG_SPARE_B, 2'b01);
        send_byte(8'h78);
        send_byte(8'h9A);
        send_byte(8'hBC);
    endtask

    task automatic test_output_backpressure;
        wait_idle();
        cfg_write(CFG_MODULATION, MOD_QAM64);
        cfg_write(CFG_DIRECTION, {1'b0, DIR_RX});
        hold_req++;
        send_block(72);
    endtask

    task automatic test_steady_stream;
        wait_idle();
        no_gaps = 1'b1;
        cfg_write(CFG_MODULATION, MOD_QPSK);
        cfg_write(CFG_DIRECTION, {1'b0, DIR_TX});
        send_block(48);
        wait_idle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_phases;
        int n;
        int part;
        while (bytes_accepted < ITEMS_TARGET) begin
            wait_idle();
            cfg_write(CFG_MODULATION, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 1)) cfg_write(CFG_DIRECTION, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          2'($urandom_range(0, 3)));
            n = block_len(cur_mod);
            for (int k = $urandom_range(1, 3); k > 0; k--) begin
                case ($urandom_range(0, 5))
                    0: begin
                        send_block($urandom_range(1, n - 1));
                        wait_idle();
                        cfg_write(CFG_MODULATION, cur_mod);
                    end
                    1: begin
                        part = $urandom_range(1, n - 1);
                        send_block(part);
                        wait_idle();
                        cfg_write(CFG_DIRECTION, 2'($urandom_range(0, 3)));
                        send_block(n - part);
                    end
                    default: send_block(n);
                endcase
            end
        end
    endtask

    initial begin
        int waited;
        error_count    = 0;
        bytes_accepted = 0;
        no_gaps        = 1'b0;
        hold_req       = 0;
        fill_count     = '0;
        cur_mod        = MOD_BPSK;
        cur_dir        = DIR_TX;
        symbol_bits    = '0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_MODULATION;
        i_cfg_data     = 2'b00;
        i_in_valid     = 1'b0;
        i_data_byte    = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_bpsk_both_directions();
        test_rewrites_mid_block();
        test_output_backpressure();
        test_steady_stream();
        test_random_phases();

        i_in_valid = 1'b0;
        waited = 0;
        while (permuted_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (permuted_q.size() != 0)
            report_mismatch($sformatf("%0d bytes never emitted", permuted_q.size()));
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ofdm_bi_pkg.sv
rtl/ofdm_bi_ctrl.sv
rtl/ofdm_bi_datapath.sv
rtl/ofdm_block_bit_interleaver.sv
bench/testbench.sv
